>>> rtl/isl_pkg.sv
// ----------------------------------------------------------------------------
// isl_pkg
// Shared types and constants for the indexed shift list.
// ----------------------------------------------------------------------------
package isl_pkg;

    localparam int DEPTH  = 128;
    localparam int WORD_W = 32;
    localparam int CNT_W  = 8;
    localparam int CMD_W  = 3;
    localparam int ST_W   = 2;
    localparam int GRP    = 16;
    localparam int NGRP   = (DEPTH + GRP - 1) / GRP;
    localparam int ADDR_W = 3;

    localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REM_LAST = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_AT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_W-1:0] ST_BADIDX = 2'd3;

    localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 3'd0;

    typedef struct packed {
        logic              ins;
        logic              del;
        logic              tap;
        logic [CNT_W-1:0]  idx;
        logic [CNT_W-1:0]  hi;
        logic [WORD_W-1:0] value;
    } t_cell_ctl;

endpackage

>>> rtl/indexed_shift_list_core.sv
// ----------------------------------------------------------------------------
// indexed_shift_list_core
// Bounded ordered list of words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Result path: the word is registered at the cell tap, then at the group OR,
//   then the final OR goes into the result register.
// Flow: no new word is taken while one is in flight; the next word is taken
//   in the cycle the result is taken.
// Reset: synchronous, active low; count cleared, capacity set to 128; cell
//   contents are not cleared.
module indexed_shift_list_core
    import isl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [WORD_W-1:0] i_value,
    input  logic [7:0]        i_index,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ST_W-1:0]   o_status,
    output logic [WORD_W-1:0] o_word_out,
    output logic [CNT_W-1:0]  o_count_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TAP  = 2'd1;
    localparam logic [1:0] S_GRP  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [7:0]        r_capacity;
    logic [ST_W-1:0]   r_status;
    logic [ST_W-1:0]   n_status;
    logic [CNT_W-1:0]  r_count_out;
    logic [WORD_W-1:0] r_word_out;

    logic              accept;
    logic              take;
    logic              full;
    logic              empty;
    logic [CNT_W-1:0]  lim;
    t_cell_ctl         ctl;
    t_cell_ctl         ctl_q;

    logic [WORD_W-1:0] w_word [DEPTH];
    logic [WORD_W-1:0] w_tap  [DEPTH];
    logic [WORD_W-1:0] red_word;

    // apb
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAPACITY) ? {24'd0, r_capacity} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 8'd128;
        end else if (psel && penable && pwrite && paddr == ADDR_CAPACITY) begin
            r_capacity <= pwdata[7:0];
        end
    end

    // handshake
    assign take    = (r_state == S_OUT) && !i_stall;
    assign o_stall = !((r_state == S_IDLE) || take);
    assign accept  = i_valid && !o_stall;
    assign o_valid = (r_state == S_OUT);

    // decode
    assign lim   = (r_capacity < CNT_W'(DEPTH)) ? r_capacity : CNT_W'(DEPTH);
    assign full  = (r_count >= lim);
    assign empty = (r_count == '0);

    always_comb begin
        ctl       = '0;
        ctl.value = i_value;
        n_status  = ST_OK;
        n_count   = r_count;
        case (i_cmd)
            CMD_APPEND: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctl.ins = 1'b1;
                    ctl.idx = r_count;
                    ctl.hi  = r_count;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_REM_LAST: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    ctl.del = 1'b1;
                    ctl.tap = 1'b1;
                    ctl.idx = r_count - 1'b1;
                    ctl.hi  = r_count - 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else if (i_index > r_count) begin
                    n_status = ST_BADIDX;
                end else begin
                    ctl.ins = 1'b1;
                    ctl.idx = i_index;
                    ctl.hi  = r_count;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_REM_AT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (i_index >= r_count) begin
                    n_status = ST_BADIDX;
                end else begin
                    ctl.del = 1'b1;
                    ctl.tap = 1'b1;
                    ctl.idx = i_index;
                    ctl.hi  = r_count - 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_READ: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (i_index >= r_count) begin
                    n_status = ST_BADIDX;
                end else begin
                    ctl.tap = 1'b1;
                    ctl.idx = i_index;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        ctl_q     = ctl;
        ctl_q.ins = ctl.ins && accept;
        ctl_q.del = ctl.del && accept;
        ctl_q.tap = ctl.tap && accept;
    end

    // cell row
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;

        if (i == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = w_word[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = w_word[i+1];
        end

        isl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl_q),
            .i_pos   (CNT_W'(i)),
            .i_left  (left),
            .i_right (right),
            .o_word  (w_word[i]),
            .o_tap   (w_tap[i])
        );
    end

    isl_reduce u_reduce (
        .i_clk  (i_clk),
        .i_tap  (w_tap),
        .o_word (red_word)
    );

    // control
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  n_state = accept ? S_TAP : S_IDLE;
            S_TAP:   n_state = S_GRP;
            S_GRP:   n_state = S_OUT;
            S_OUT:   n_state = accept ? S_TAP : (take ? S_IDLE : S_OUT);
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_count_out <= n_count;
        end
        if (r_state == S_GRP) begin
            r_word_out <= red_word;
        end
    end

    assign o_status    = r_status;
    assign o_word_out  = r_word_out;
    assign o_count_out = r_count_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count beyond depth");

    a_accept_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (r_state == S_IDLE || r_state == S_OUT))
        else $error("word accepted while busy");

    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_status != ST_OK) |=> r_count == $past(r_count))
        else $error("rejected command changed count");

    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd == CMD_APPEND || i_cmd == CMD_INSERT) && n_status == ST_OK)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow count");

    a_tap_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP) |=> (r_state == S_GRP) ##1 (r_state == S_OUT))
        else $error("result pipeline out of step");
`endif

endmodule

>>> rtl/isl_cell.sv
// ----------------------------------------------------------------------------
// isl_cell
// One list position: holds a word, shifts from a neighbour and taps it out.
// ----------------------------------------------------------------------------
module isl_cell
    import isl_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [CNT_W-1:0]  i_pos,
    input  logic [WORD_W-1:0] i_left,
    input  logic [WORD_W-1:0] i_right,
    output logic [WORD_W-1:0] o_word,
    output logic [WORD_W-1:0] o_tap
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic [WORD_W-1:0] r_tap;
    logic              hit;

    assign hit = (i_pos == i_ctl.idx);

    always_comb begin
        n_word = r_word;
        if (i_ctl.ins) begin
            if (hit) begin
                n_word = i_ctl.value;
            end else if (i_pos > i_ctl.idx && i_pos <= i_ctl.hi) begin
                n_word = i_left;
            end
        end else if (i_ctl.del) begin
            if (i_pos >= i_ctl.idx && i_pos < i_ctl.hi) begin
                n_word = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_tap  <= (i_ctl.tap && hit) ? r_word : '0;
    end

    assign o_word = r_word;
    assign o_tap  = r_tap;

endmodule

>>> rtl/isl_reduce.sv
// ----------------------------------------------------------------------------
// isl_reduce
// Two-level OR tree over the cell taps; first level registered.
// ----------------------------------------------------------------------------
module isl_reduce
    import isl_pkg::*;
(
    input  logic              i_clk,
    input  logic [WORD_W-1:0] i_tap [DEPTH],
    output logic [WORD_W-1:0] o_word
);

    logic [WORD_W-1:0] r_grp [NGRP];
    logic [WORD_W-1:0] n_grp [NGRP];

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        always_comb begin
            n_grp[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                if (g * GRP + k < DEPTH) begin
                    n_grp[g] = n_grp[g] | i_tap[g * GRP + k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_grp[g] <= n_grp[g];
        end
    end

    always_comb begin
        o_word = '0;
        for (int g = 0; g < NGRP; g++) begin
            o_word = o_word | r_grp[g];
        end
    end

endmodule
